FILE: hdl/tif_pkg.sv
package tif_pkg;

  // FIFO geometry. The ring keeps one slot free, so it holds FIFO_DEPTH-1 bytes.
  localparam int FIFO_DEPTH = 4096;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Telnet command and option codes.
  localparam logic [7:0] B_IAC     = 8'hFF;
  localparam logic [7:0] B_DONT    = 8'hFE;
  localparam logic [7:0] B_DO      = 8'hFD;
  localparam logic [7:0] B_WONT    = 8'hFC;
  localparam logic [7:0] B_WILL    = 8'hFB;
  localparam logic [7:0] B_SB      = 8'hFA;
  localparam logic [7:0] B_SE      = 8'hF0;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] QUAL_IS   = 8'd0;
  localparam logic [7:0] QUAL_SEND = 8'd1;

  // Console characters.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_GS     = 8'h1D;
  localparam logic [7:0] CH_B3     = 8'hB3;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;

  // Codes that arrow keys turn into.
  localparam logic [7:0] KEY_UP    = 8'd16;
  localparam logic [7:0] KEY_DOWN  = 8'd14;
  localparam logic [7:0] KEY_RIGHT = 8'd6;
  localparam logic [7:0] KEY_LEFT  = 8'd2;

  // Request and result kinds.
  localparam logic REQ_RX      = 1'b0;
  localparam logic REQ_READ    = 1'b1;
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

  // Terminal type request sent back on WILL TTYPE.
  localparam int REPLY_LEN = 6;
  localparam int REPLY_IW  = $clog2(REPLY_LEN);

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
  } out_item_t;

  // What the parser makes of one received byte: up to three stores, or a reply.
  typedef struct packed {
    logic [1:0]      npush;
    logic [2:0][7:0] bytes;
    logic            reply;
  } parse_res_t;

  // One FIFO operation per cycle.
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       pop;
  } fifo_cmd_t;

  function automatic logic [7:0] reply_byte(input logic [REPLY_IW-1:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = B_IAC;
      3'd1:    b = B_SB;
      3'd2:    b = OPT_TTYPE;
      3'd3:    b = QUAL_SEND;
      3'd4:    b = B_IAC;
      3'd5:    b = B_SE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/tif_parser.sv
module tif_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  output tif_pkg::parse_res_t res
);
  import tif_pkg::*;

  localparam logic [3:0] ST_TEXT   = 4'd0;
  localparam logic [3:0] ST_VT1    = 4'd1;
  localparam logic [3:0] ST_VT2    = 4'd2;
  localparam logic [3:0] ST_REMOTE = 4'd3;
  localparam logic [3:0] ST_CMD    = 4'd4;
  localparam logic [3:0] ST_OPT    = 4'd5;
  localparam logic [3:0] ST_SB1    = 4'd6;
  localparam logic [3:0] ST_SB2    = 4'd7;
  localparam logic [3:0] ST_SBTT   = 4'd8;
  localparam logic [3:0] ST_SKIP   = 4'd9;

  logic       terminal_mode;
  logic [3:0] state;
  logic [3:0] state_next;
  logic [7:0] last_command;
  logic [7:0] last_command_next;
  logic [7:0] last_option;
  logic [7:0] last_option_next;

  // Next parser state and the bytes that this byte stores.
  always_comb begin
    state_next        = state;
    last_command_next = last_command;
    last_option_next  = last_option;
    res               = '0;
    if (!terminal_mode) begin
      res.npush    = 2'd1;
      res.bytes[0] = rx_byte;
    end else begin
      case (state)
        ST_TEXT: begin
          if (rx_byte == CH_ESC) begin
            state_next = ST_VT1;
          end else if (rx_byte inside {CH_GS, CH_B3}) begin
            state_next = ST_REMOTE;
          end else if (rx_byte == B_IAC) begin
            state_next = ST_CMD;
          end else if (!(rx_byte inside {CH_NUL, CH_LF})) begin
            res.npush    = 2'd1;
            res.bytes[0] = rx_byte;
          end
        end
        ST_VT1: begin
          if (rx_byte == CH_LBRACK) begin
            state_next = ST_VT2;
          end else begin
            res.npush    = 2'd2;
            res.bytes[0] = CH_ESC;
            res.bytes[1] = rx_byte;
            state_next   = ST_TEXT;
          end
        end
        ST_VT2: begin
          res.npush = 2'd1;
          case (rx_byte)
            CH_A:    res.bytes[0] = KEY_UP;
            CH_B:    res.bytes[0] = KEY_DOWN;
            CH_C:    res.bytes[0] = KEY_RIGHT;
            CH_D:    res.bytes[0] = KEY_LEFT;
            default: begin
              res.npush    = 2'd3;
              res.bytes[0] = CH_ESC;
              res.bytes[1] = CH_LBRACK;
              res.bytes[2] = rx_byte;
            end
          endcase
          state_next = ST_TEXT;
        end
        ST_REMOTE: begin
          state_next = ST_TEXT;
        end
        ST_CMD: begin
          last_command_next = rx_byte;
          if (rx_byte inside {B_WILL, B_WONT, B_DO, B_DONT}) begin
            state_next = ST_OPT;
          end else if (rx_byte == B_SB) begin
            state_next = ST_SB1;
          end else begin
            if (rx_byte == B_IAC) begin
              res.npush    = 2'd1;
              res.bytes[0] = B_IAC;
            end
            state_next = ST_TEXT;
          end
        end
        ST_OPT: begin
          last_option_next = rx_byte;
          state_next       = ST_TEXT;
          res.reply        = (last_command == B_WILL) && (rx_byte == OPT_TTYPE);
        end
        ST_SB1: begin
          last_option_next = rx_byte;
          state_next       = ST_SB2;
        end
        ST_SB2: begin
          if ((last_option == OPT_TTYPE) && (rx_byte == QUAL_IS)) begin
            state_next = ST_SBTT;
          end else begin
            state_next = ST_SKIP;
          end
        end
        ST_SBTT: begin
          state_next = ST_SKIP;
        end
        ST_SKIP: begin
          if (rx_byte == B_IAC) begin
            state_next = ST_CMD;
          end
        end
        default: begin
          state_next = ST_TEXT;
        end
      endcase
    end
  end

  // Parser registers and the mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_mode <= 1'b1;
      state         <= ST_TEXT;
      last_command  <= 8'h00;
      last_option   <= 8'h00;
    end else begin
      if (cfg_we) begin
        terminal_mode <= cfg_wdata;
      end
      if (step) begin
        state        <= state_next;
        last_command <= last_command_next;
        last_option  <= last_option_next;
      end
    end
  end

endmodule

FILE: hdl/tif_fifo.sv
module tif_fifo (
  input  logic              clk,
  input  logic              rst,
  input  tif_pkg::fifo_cmd_t cmd,
  output logic              empty,
  output logic [7:0]        rd_data
);
  import tif_pkg::*;

  logic [7:0]         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head;
  logic [FIFO_AW-1:0] tail;
  logic [FIFO_AW-1:0] head_next;
  logic [FIFO_AW-1:0] tail_next;
  logic               full;

  function automatic logic [FIFO_AW-1:0] wrap_inc(input logic [FIFO_AW-1:0] i);
    logic [FIFO_AW-1:0] n;
    if (i == FIFO_AW'(FIFO_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = i + 1'b1;
    end
    return n;
  endfunction

  // One slot stays free so that equal pointers mean empty.
  assign head_next = wrap_inc(head);
  assign tail_next = wrap_inc(tail);
  assign empty     = (head == tail);
  assign full      = (tail_next == head);

  // Storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[tail] <= cmd.push_byte;
    end
    if (cmd.pop) begin
      rd_data <= mem[head];
    end
  end

  // Ring pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (cmd.push && !full) begin
        tail <= tail_next;
      end
      if (cmd.pop) begin
        head <= head_next;
      end
    end
  end

endmodule

FILE: hdl/telnet_input_filter_fifo_top.sv
// Channel  Signals                      Beat
// -------  ---------------------------  ----------------------------------------
// in       in_valid, in_ready, in_data  read request or one received byte
// out      out_valid, out_ready, out_data  read answer or one reply byte
// cfg      cfg_we, cfg_wdata            terminal mode, taken on any enable edge
//
// A received byte is parsed when it is taken and then stores its bytes one at a
// time (one to three, set by the single memory write port), so plain text streams
// at one byte per cycle. A read pops the ring and then emits the registered read
// data; an empty read answers without a pop. WILL TTYPE sends its six reply beats.
// Synchronous reset empties the ring by clearing its pointers; no clearing pass.
// A stall on out holds the next item in the work stage; in_ready then drops.
module telnet_input_filter_fifo_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tif_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tif_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import tif_pkg::*;

  logic                accept;
  logic                step;
  parse_res_t          pres;
  fifo_cmd_t           fcmd;
  logic                fifo_empty;
  logic [7:0]          fifo_rd_data;

  logic                wk_valid;
  logic                wk_read;
  logic                wk_phase;
  logic [2:0][7:0]     wk_bytes;
  logic [1:0]          wk_npush;
  logic                wk_reply;
  logic [REPLY_IW-1:0] wk_ridx;

  logic                out_free;
  logic                emit;
  out_item_t           emit_item;
  logic                done;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !wk_valid || done;
  assign accept   = in_valid && in_ready;
  assign step     = accept && (in_data.req_type == REQ_RX);

  tif_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .rx_byte   (in_data.rx_byte),
    .res       (pres)
  );

  tif_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .cmd     (fcmd),
    .empty   (fifo_empty),
    .rd_data (fifo_rd_data)
  );

  // One action of the current item per cycle unless out is stalled: a store, a pop, or an output beat.
  always_comb begin
    fcmd      = '0;
    emit      = 1'b0;
    emit_item = '0;
    done      = 1'b0;
    if (wk_valid) begin
      if (wk_read) begin
        if (!wk_phase) begin
          if (fifo_empty) begin
            if (out_free) begin
              emit                  = 1'b1;
              emit_item.result_kind = KIND_READ;
              emit_item.last        = 1'b1;
              done                  = 1'b1;
            end
          end else begin
            fcmd.pop = 1'b1;
          end
        end else if (out_free) begin
          emit                  = 1'b1;
          emit_item.result_kind = KIND_READ;
          emit_item.data_byte   = fifo_rd_data;
          emit_item.data_valid  = 1'b1;
          emit_item.last        = 1'b1;
          done                  = 1'b1;
        end
      end else if (wk_npush != 2'd0) begin
        fcmd.push      = 1'b1;
        fcmd.push_byte = wk_bytes[0];
        done           = (wk_npush == 2'd1);
      end else if (wk_reply) begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_item.result_kind = KIND_REPLY;
          emit_item.data_byte   = reply_byte(wk_ridx);
          emit_item.data_valid  = 1'b1;
          emit_item.last        = (wk_ridx == REPLY_IW'(REPLY_LEN - 1));
          done                  = emit_item.last;
        end
      end else begin
        done = 1'b1;
      end
    end
  end

  // Work stage: holds the item being carried out.
  always_ff @(posedge clk) begin
    if (rst) begin
      wk_valid <= 1'b0;
      wk_read  <= 1'b0;
      wk_phase <= 1'b0;
      wk_npush <= 2'd0;
      wk_reply <= 1'b0;
      wk_ridx  <= '0;
    end else if (accept) begin
      wk_valid <= 1'b1;
      wk_read  <= (in_data.req_type == REQ_READ);
      wk_phase <= 1'b0;
      wk_npush <= (in_data.req_type == REQ_READ) ? 2'd0 : pres.npush;
      wk_reply <= (in_data.req_type == REQ_RX) && pres.reply;
      wk_ridx  <= '0;
    end else begin
      if (done) begin
        wk_valid <= 1'b0;
      end
      if (fcmd.pop) begin
        wk_phase <= 1'b1;
      end
      if (fcmd.push) begin
        wk_npush <= wk_npush - 2'd1;
      end
      if (emit && wk_reply) begin
        wk_ridx <= wk_ridx + 1'b1;
      end
    end
  end

  // Bytes still to store, oldest in slot zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      wk_bytes <= pres.bytes;
    end else if (fcmd.push) begin
      wk_bytes <= {8'h00, wk_bytes[2:1]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_item;
    end
  end

endmodule

FILE: tb/telnet_input_filter_fifo_top_tb.sv
`timescale 1ns / 1ps

module telnet_input_filter_fifo_top_tb;
  import tif_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;

  // Parser states of the shadow filter.
  typedef enum logic [3:0] {
    PS_TEXT,
    PS_ESC,
    PS_CSI,
    PS_SWALLOW,
    PS_CMD,
    PS_OPT,
    PS_SB_OPT,
    PS_SB_QUAL,
    PS_SB_TTYPE,
    PS_SB_SKIP
  } parse_state_e;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  // Shadow copy of the filter state and the receive ring.
  logic         term_mode = 1'b1;
  parse_state_e parse_st  = PS_TEXT;
  logic [7:0]   last_cmd  = '0;
  logic [7:0]   last_opt  = '0;
  logic [7:0]   shadow_fifo [FIFO_DEPTH];
  int           fifo_head = 0;
  int           fifo_tail = 0;
  out_item_t    expected_beats [$];

  bit idle_on        = 1'b1;
  int stall_left     = 0;
  int quiet_cycles   = 0;
  int mismatch_count = 0;
  int in_beats       = 0;
  int out_beats      = 0;
  int reply_beats    = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  telnet_input_filter_fifo_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int fifo_count();
    return (fifo_tail - fifo_head + FIFO_DEPTH) % FIFO_DEPTH;
  endfunction

  // A byte that would make the ring look empty again is dropped.
  function automatic void store_byte(input logic [7:0] b);
    int nxt;
    nxt = (fifo_tail + 1) % FIFO_DEPTH;
    if (nxt != fifo_head) begin
      shadow_fifo[fifo_tail] = b;
      fifo_tail = nxt;
    end
  endfunction

  function automatic void queue_ttype_reply();
    logic [7:0] seq [REPLY_LEN];
    out_item_t  r;
    seq = '{B_IAC, B_SB, OPT_TTYPE, QUAL_SEND, B_IAC, B_SE};
    for (int k = 0; k < REPLY_LEN; k++) begin
      r.result_kind = KIND_REPLY;
      r.data_byte   = seq[k];
      r.data_valid  = 1'b1;
      r.last        = (k == REPLY_LEN - 1);
      expected_beats.push_back(r);
    end
  endfunction

  // Telnet and escape parsing of one received byte.
  function automatic void parse_rx(input logic [7:0] c);
    case (parse_st)
      PS_TEXT: begin
        if (c == CH_ESC) parse_st = PS_ESC;
        else if (c == CH_GS || c == CH_B3) parse_st = PS_SWALLOW;
        else if (c == B_IAC) parse_st = PS_CMD;
        else if (c != CH_NUL && c != CH_LF) store_byte(c);
      end
      PS_ESC: begin
        if (c == CH_LBRACK) begin
          parse_st = PS_CSI;
        end else begin
          store_byte(CH_ESC);
          store_byte(c);
          parse_st = PS_TEXT;
        end
      end
      PS_CSI: begin
        case (c)
          CH_A: store_byte(KEY_UP);
          CH_B: store_byte(KEY_DOWN);
          CH_C: store_byte(KEY_RIGHT);
          CH_D: store_byte(KEY_LEFT);
          default: begin
            store_byte(CH_ESC);
            store_byte(CH_LBRACK);
            store_byte(c);
          end
        endcase
        parse_st = PS_TEXT;
      end
      PS_SWALLOW: parse_st = PS_TEXT;
      PS_CMD: begin
        last_cmd = c;
        if (c == B_WILL || c == B_WONT || c == B_DO || c == B_DONT) begin
          parse_st = PS_OPT;
        end else if (c == B_SB) begin
          parse_st = PS_SB_OPT;
        end else begin
          if (c == B_IAC) store_byte(B_IAC);
          parse_st = PS_TEXT;
        end
      end
      PS_OPT: begin
        last_opt = c;
        parse_st = PS_TEXT;
        if (last_cmd == B_WILL && c == OPT_TTYPE) queue_ttype_reply();
      end
      PS_SB_OPT: begin
        last_opt = c;
        parse_st = PS_SB_QUAL;
      end
      PS_SB_QUAL: begin
        if (last_opt == OPT_TTYPE && c == QUAL_IS) parse_st = PS_SB_TTYPE;
        else parse_st = PS_SB_SKIP;
      end
      PS_SB_TTYPE: parse_st = PS_SB_SKIP;
      PS_SB_SKIP: begin
        if (c == B_IAC) parse_st = PS_CMD;
      end
      default: parse_st = PS_TEXT;
    endcase
  endfunction

  // Expected behavior for one accepted input beat.
  function automatic void predict_beat(input in_item_t it);
    out_item_t r;
    if (it.req_type == REQ_READ) begin
      r.result_kind = KIND_READ;
      r.last        = 1'b1;
      if (fifo_head == fifo_tail) begin
        r.data_byte  = 8'h00;
        r.data_valid = 1'b0;
      end else begin
        r.data_byte  = shadow_fifo[fifo_head];
        r.data_valid = 1'b1;
        fifo_head    = (fifo_head + 1) % FIFO_DEPTH;
      end
      expected_beats.push_back(r);
    end else if (!term_mode) begin
      store_byte(it.rx_byte);
    end else begin
      parse_rx(it.rx_byte);
    end
  endfunction

  // Sends one input beat, with an occasional idle burst in front of it.
  task automatic send_beat(input logic req, input logic [7:0] b);
    int       gap;
    in_item_t beat;
    beat.req_type = req;
    beat.rx_byte  = b;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    predict_beat(beat);
    in_beats++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_beat(REQ_RX, b);
  endtask

  // The byte field of a read is don't-care, so it is randomized.
  task automatic send_read();
    send_beat(REQ_READ, 8'($urandom_range(0, 255)));
  endtask

  // Waits until every expected beat has arrived and pending stores have retired.
  task automatic wait_settled();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_terminal_mode(input logic mode);
    wait_settled();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    term_mode = mode;
  endtask

  // Reads every stored byte and then once more on the empty ring.
  task automatic drain_fifo();
    int n;
    n = fifo_count() + 1;
    repeat (n) send_read();
  endtask

  // One random sequence, mostly well formed, the rest noise.
  task automatic random_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_read();
    end else if (pick < 48) begin
      repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(32, 126)));
    end else if (pick < 58) begin
      send_rx(CH_ESC);
      if ($urandom_range(0, 4) != 0) begin
        send_rx(CH_LBRACK);
        if ($urandom_range(0, 3) != 0) send_rx(8'(CH_A + $urandom_range(0, 3)));
        else send_rx(8'($urandom_range(0, 255)));
      end else begin
        send_rx(8'($urandom_range(0, 255)));
      end
    end else if (pick < 70) begin
      send_rx(B_IAC);
      if ($urandom_range(0, 1) == 0) send_rx(B_WILL);
      else send_rx(8'(B_WILL + $urandom_range(0, 3)));
      if ($urandom_range(0, 1) == 0) send_rx(OPT_TTYPE);
      else send_rx(8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      send_rx(B_IAC);
      send_rx(B_SB);
      send_rx($urandom_range(0, 1) ? OPT_TTYPE : 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 2))
        0: send_rx(QUAL_IS);
        1: send_rx(QUAL_SEND);
        default: send_rx(8'($urandom_range(0, 255)));
      endcase
      repeat ($urandom_range(0, 3)) send_rx(8'($urandom_range(0, 254)));
      send_rx(B_IAC);
      send_rx(B_SE);
    end else if (pick < 85) begin
      send_rx(B_IAC);
      if ($urandom_range(0, 1) == 0) send_rx(B_IAC);
      else send_rx(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      send_rx($urandom_range(0, 1) ? CH_GS : CH_B3);
      send_rx(8'($urandom_range(0, 255)));
    end else begin
      send_rx(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(input logic mode, input int n);
    int target;
    set_terminal_mode(mode);
    target = in_beats + n;
    while (in_beats < target) random_sequence();
  endtask

  // Tests.

  task automatic test_empty_reads();
    send_read();
    send_read();
  endtask

  task automatic test_arrow_keys();
    logic [7:0] keys [4];
    keys = '{CH_A, CH_B, CH_C, CH_D};
    foreach (keys[i]) begin
      send_rx(CH_ESC);
      send_rx(CH_LBRACK);
      send_rx(keys[i]);
    end
    drain_fifo();
  endtask

  task automatic test_unknown_escapes();
    send_rx(CH_ESC);
    send_rx(8'h71);
    send_rx(CH_ESC);
    send_rx(CH_LBRACK);
    send_rx(8'hFF);
    drain_fifo();
  endtask

  task automatic test_dropped_bytes();
    send_rx(CH_NUL);
    send_rx(CH_LF);
    send_rx(CH_GS);
    send_rx(8'h78);
    send_rx(CH_B3);
    send_rx(B_IAC);
    send_rx(8'h6B);
    drain_fifo();
  endtask

  task automatic test_iac_commands();
    send_rx(B_IAC);
    send_rx(B_IAC);
    send_rx(B_IAC);
    send_rx(B_SE);
    send_rx(B_IAC);
    send_rx(B_WILL);
    send_rx(OPT_TTYPE);
    send_rx(B_IAC);
    send_rx(B_DO);
    send_rx(OPT_TTYPE);
    send_rx(B_IAC);
    send_rx(B_WILL);
    send_rx(8'h01);
    send_rx(8'h7A);
    drain_fifo();
  endtask

  // TTYPE IS skips one extra byte, here an IAC that must not end the skip.
  task automatic test_subnegotiation();
    send_rx(B_IAC);
    send_rx(B_SB);
    send_rx(OPT_TTYPE);
    send_rx(QUAL_IS);
    send_rx(B_IAC);
    send_rx(8'h61);
    send_rx(B_IAC);
    send_rx(B_SE);
    send_rx(B_IAC);
    send_rx(B_SB);
    send_rx(8'h1F);
    send_rx(QUAL_SEND);
    send_rx(B_IAC);
    send_rx(B_IAC);
    drain_fifo();
  endtask

  // Raw bytes are stored as they are, and the parser resumes where it stopped.
  task automatic test_raw_mode();
    send_rx(CH_ESC);
    set_terminal_mode(1'b0);
    send_rx(CH_NUL);
    send_rx(CH_LF);
    send_rx(CH_ESC);
    send_rx(B_IAC);
    send_rx(CH_GS);
    send_rx(CH_B3);
    set_terminal_mode(1'b1);
    send_rx(CH_LBRACK);
    send_rx(CH_A);
    drain_fifo();
  endtask

  task automatic test_random_traffic();
    random_phase(1'b1, 100);
    random_phase(1'b0, 40);
    random_phase(1'b1, 80);
    drain_fifo();
  endtask

  // No idling on either side, with replies packed back to back.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (4) begin
      send_rx(B_IAC);
      send_rx(B_WILL);
      send_rx(OPT_TTYPE);
    end
    repeat (40) random_sequence();
    drain_fifo();
  endtask

  // Receiver stalls in random bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares each output beat with the oldest expected one.
  always @(posedge clk) begin : check_output
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      out_beats++;
      if (out_data.result_kind == KIND_REPLY) reply_beats++;
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected output beat kind=%0d data=%02h valid=%0d last=%0d",
                   $time, out_data.result_kind, out_data.data_byte,
                   out_data.data_valid, out_data.last);
      end else begin
        want = expected_beats.pop_front();
        if (out_data.result_kind !== want.result_kind ||
            out_data.data_byte !== want.data_byte ||
            out_data.data_valid !== want.data_valid ||
            out_data.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: beat %0d expected kind=%0d data=%02h valid=%0d last=%0d",
                     $time, out_beats, want.result_kind, want.data_byte,
                     want.data_valid, want.last);
            $display("%0t: beat %0d got      kind=%0d data=%02h valid=%0d last=%0d",
                     $time, out_beats, out_data.result_kind,
                     out_data.data_byte, out_data.data_valid, out_data.last);
          end
        end
      end
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_beats.size());
      $display("telnet_input_filter_fifo_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_reads();
    test_arrow_keys();
    test_unknown_escapes();
    test_dropped_bytes();
    test_iac_commands();
    test_subnegotiation();
    test_raw_mode();
    test_random_traffic();
    test_back_to_back();
    wait_settled();

    $display("Sent %0d input beats and checked %0d output beats, %0d of them reply bytes.",
             in_beats, out_beats, reply_beats);
    $display("Covered escape and Telnet parsing, raw mode, subnegotiation and empty reads.");
    if (mismatch_count != 0 || expected_beats.size() != 0)
      $display("%0d mismatches, %0d results never arrived",
               mismatch_count, expected_beats.size());
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("telnet_input_filter_fifo_top_tb: PASS");
    end else begin
      $display("telnet_input_filter_fifo_top_tb: FAIL");
    end
    $finish;
  end

endmodule
